>>> hdl/sds_pkg.sv
// shared types and constants for the scan disk scheduler
// no dependencies; every other file imports this package
package sds_pkg;

  localparam int N_CELLS    = 32;
  localparam int TRACK_BITS = 16;
  localparam int IDX_W      = $clog2(N_CELLS);
  localparam int CNT_W      = $clog2(N_CELLS + 1);
  localparam int TC_W       = TRACK_BITS + 1;
  localparam int TOT_W      = TRACK_BITS + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TC_W;

  localparam logic [TC_W-1:0] TRACK_LIMIT     = {1'b1, {TRACK_BITS{1'b0}}};
  localparam logic [TC_W-1:0] TRACK_COUNT_RST = TC_W'(200);

  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_RIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TRACK = 2'd2;

  // what one sort cell shows its right-hand neighbor
  typedef struct packed {
    logic                  valid;
    logic                  gt;
    logic [TRACK_BITS-1:0] value;
  } sds_link_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FIRST,
    ST_MID,
    ST_SECOND,
    ST_END,
    ST_FLUSH
  } sds_state_t;

endpackage

>>> hdl/sds_req_if.sv
// request channel: one pending track per transaction
// depends on sds_pkg
interface sds_req_if;
  import sds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [TRACK_BITS-1:0] request_track;
  logic                  last_request;

  modport source(output valid, request_track, last_request, input ready);
  modport sink(input valid, request_track, last_request, output ready);
endinterface

>>> hdl/sds_move_if.sv
// move channel: one head move per transaction
// depends on sds_pkg
interface sds_move_if;
  import sds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [TRACK_BITS-1:0] from_track;
  logic [TRACK_BITS-1:0] to_track;
  logic [TOT_W-1:0]      total_movement;
  logic                  last_move;

  modport source(output valid, from_track, to_track, total_movement, last_move, input ready);
  modport sink(input valid, from_track, to_track, total_movement, last_move, output ready);
endinterface

>>> hdl/scan_disk_scheduler.sv
// scan disk scheduler: loads one request per cycle while in its load state, then emits the elevator order
// after the last request the sequencer reads one sort cell per cycle unless the move
// output is stalled
// throughput: at most one move a cycle, set by the single read port on the cell row
// reset: sync active high, clears cells, counts and fsm; config returns to 200/0/0
// depends on sds_pkg, sds_req_if, sds_move_if, sds_sorter
module scan_disk_scheduler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sds_pkg::CFG_DATA_W-1:0] cfg_wdata,
  sds_req_if.sink                        req,
  sds_move_if.source                     mv
);
  import sds_pkg::*;

  logic [TC_W-1:0]       track_count;
  logic                  sweep_right;
  logic [TRACK_BITS-1:0] start_track;

  sds_state_t            state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic [TRACK_BITS-1:0] prev, prev_next;
  logic [TRACK_BITS-1:0] start_r, start_next;
  logic [TRACK_BITS-1:0] edge_r, edge_next;
  logic                  right_r, right_next;
  logic                  pend_v, pend_v_next;
  logic [TRACK_BITS-1:0] pend_from, pend_from_next;
  logic [TRACK_BITS-1:0] pend_to, pend_to_next;
  logic                  out_valid, out_valid_next;
  logic [TRACK_BITS-1:0] out_from, out_from_next;
  logic [TRACK_BITS-1:0] out_to, out_to_next;
  logic [TOT_W-1:0]      out_total, out_total_next;
  logic                  out_last, out_last_next;

  logic [TRACK_BITS-1:0] edge_c, req_clamped, start_clamped, cur, pt;
  logic [CNT_W-1:0]      count_ins;
  logic                  req_fire, ins, clr, full, advance, down, qual, has_pt, o_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      track_count <= TRACK_COUNT_RST;
      sweep_right <= 1'b0;
      start_track <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TRACK_COUNT: track_count <= cfg_wdata;
        CFG_SWEEP_RIGHT: sweep_right <= cfg_wdata[0];
        CFG_START_TRACK: start_track <= cfg_wdata[TRACK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (track_count < TC_W'(2)) begin
      edge_c = TRACK_BITS'(1);
    end else if (track_count > TRACK_LIMIT) begin
      edge_c = '1;
    end else begin
      edge_c = TRACK_BITS'(track_count - TC_W'(1));
    end
  end

  assign req_clamped   = (req.request_track > edge_c) ? edge_c : req.request_track;
  assign start_clamped = (start_track > edge_c) ? edge_c : start_track;

  assign req.ready = (state == ST_LOAD);
  assign req_fire  = req.valid && req.ready;
  assign ins       = req_fire && !full;
  assign count_ins = count + CNT_W'(ins);
  assign advance   = !out_valid || mv.ready;

  sds_sorter u_sorter (
    .clk      (clk),
    .rst      (rst),
    .clr      (clr),
    .ins      (ins),
    .ins_track(req_clamped),
    .rd_idx   (idx),
    .rd_track (cur),
    .full     (full)
  );

  // first sweep runs down unless sweeping right; second sweep runs the other way
  assign down = (state == ST_FIRST) ? !right_r : right_r;
  assign qual = down ? (cur < start_r) : (cur > start_r);

  always_comb begin
    state_next     = state;
    count_next     = count;
    cnt_next       = cnt;
    idx_next       = idx;
    prev_next      = prev;
    start_next     = start_r;
    edge_next      = edge_r;
    right_next     = right_r;
    pend_v_next    = pend_v;
    pend_from_next = pend_from;
    pend_to_next   = pend_to;
    out_from_next  = out_from;
    out_to_next    = out_to;
    out_total_next = out_total;
    out_last_next  = out_last;
    o_load         = 1'b0;
    clr            = 1'b0;
    has_pt         = 1'b0;
    pt             = cur;

    case (state)
      ST_LOAD: begin
        if (req_fire) begin
          count_next = count_ins;
          if (req.last_request) begin
            state_next  = ST_FIRST;
            start_next  = start_clamped;
            edge_next   = edge_c;
            right_next  = sweep_right;
            prev_next   = start_clamped;
            cnt_next    = count_ins;
            idx_next    = sweep_right ? '0 : IDX_W'(count_ins - CNT_W'(1));
            pend_v_next = 1'b0;
          end
        end
      end
      ST_FIRST, ST_SECOND: begin
        if (advance) begin
          has_pt = qual && (cnt != '0);
          if (cnt <= CNT_W'(1)) begin
            state_next = (state == ST_FIRST) ? ST_MID : ST_END;
          end
          cnt_next = (cnt == '0) ? '0 : cnt - CNT_W'(1);
          idx_next = down ? idx - IDX_W'(1) : idx + IDX_W'(1);
        end
      end
      ST_MID: begin
        if (advance) begin
          has_pt     = 1'b1;
          pt         = right_r ? edge_r : '0;
          state_next = ST_SECOND;
          cnt_next   = count;
          idx_next   = right_r ? IDX_W'(count - CNT_W'(1)) : '0;
        end
      end
      ST_END: begin
        if (advance) begin
          has_pt     = 1'b1;
          pt         = right_r ? '0 : edge_r;
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (advance) begin
          o_load        = 1'b1;
          out_from_next = pend_from;
          out_to_next   = pend_to;
          out_last_next = 1'b1;
          out_total_next = right_r ? ({edge_r, 1'b0} - TOT_W'(start_r))
                                   : (TOT_W'(start_r) + TOT_W'(edge_r));
          pend_v_next   = 1'b0;
          clr           = 1'b1;
          count_next    = '0;
          state_next    = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase

    // a move is held back one step so the final one can carry the total
    if (has_pt && (pt != prev)) begin
      if (pend_v) begin
        o_load         = 1'b1;
        out_from_next  = pend_from;
        out_to_next    = pend_to;
        out_last_next  = 1'b0;
        out_total_next = '0;
      end
      pend_v_next    = 1'b1;
      pend_from_next = prev;
      pend_to_next   = pt;
      prev_next      = pt;
    end

    out_valid_next = o_load || (out_valid && !mv.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      cnt       <= '0;
      idx       <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cnt       <= cnt_next;
      idx       <= idx_next;
      pend_v    <= pend_v_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    prev      <= prev_next;
    start_r   <= start_next;
    edge_r    <= edge_next;
    right_r   <= right_next;
    pend_from <= pend_from_next;
    pend_to   <= pend_to_next;
    out_from  <= out_from_next;
    out_to    <= out_to_next;
    out_total <= out_total_next;
    out_last  <= out_last_next;
  end

  assign mv.valid          = out_valid;
  assign mv.from_track     = out_from;
  assign mv.to_track       = out_to;
  assign mv.total_movement = out_total;
  assign mv.last_move      = out_last;

endmodule

>>> hdl/sds_cell.sv
// one insertion-sort cell: holds one track, takes its left neighbor's track on insert when that track is larger
// depends on sds_pkg
module sds_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clr,
  input  logic                          ins,
  input  logic [sds_pkg::TRACK_BITS-1:0] ins_track,
  input  sds_pkg::sds_link_t            link_in,
  output sds_pkg::sds_link_t            link_out
);
  import sds_pkg::*;

  logic                  valid;
  logic [TRACK_BITS-1:0] value;
  logic                  gt;

  assign gt = valid && (value > ins_track);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (clr) begin
      valid <= 1'b0;
    end else if (ins) begin
      valid <= valid | link_in.valid;
    end
  end

  // larger entries move one cell right, the new track lands in the first cell with a larger track, else the first gap
  always_ff @(posedge clk) begin
    if (ins) begin
      if (link_in.gt) begin
        value <= link_in.value;
      end else if (gt || !valid) begin
        value <= ins_track;
      end
    end
  end

  assign link_out.valid = valid;
  assign link_out.gt    = gt;
  assign link_out.value = value;

endmodule

>>> hdl/sds_sorter.sv
// row of sort cells keeping pending tracks in ascending order, plus one read port
// depends on sds_pkg and sds_cell
module sds_sorter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clr,
  input  logic                           ins,
  input  logic [sds_pkg::TRACK_BITS-1:0] ins_track,
  input  logic [sds_pkg::IDX_W-1:0]      rd_idx,
  output logic [sds_pkg::TRACK_BITS-1:0] rd_track,
  output logic                           full
);
  import sds_pkg::*;

  sds_link_t cell_out [N_CELLS];
  sds_link_t head_link;
  logic      ins_ok;

  assign head_link = '{valid: 1'b1, gt: 1'b0, value: '0};
  assign full      = cell_out[N_CELLS-1].valid;
  assign ins_ok    = ins && !full;

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    sds_link_t lin;
    if (i == 0) begin : g_head
      assign lin = head_link;
    end else begin : g_body
      assign lin = cell_out[i-1];
    end
    sds_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (clr),
      .ins      (ins_ok),
      .ins_track(ins_track),
      .link_in  (lin),
      .link_out (cell_out[i])
    );
  end

  assign rd_track = cell_out[rd_idx].value;

endmodule

>>> hdl/sds_checker.sv
// port-level checks for the scan disk scheduler, attached with bind
// depends on scan_disk_scheduler ports and sds_pkg
module sds_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           req_last,
  input logic                           mv_valid,
  input logic                           mv_ready,
  input logic                           mv_last,
  input logic [sds_pkg::TOT_W-1:0]      mv_total
);
  import sds_pkg::*;

  // a stalled move stays offered
  a_mv_hold: assert property (@(posedge clk) disable iff (rst)
    mv_valid && !mv_ready |=> mv_valid)
    else $error("move dropped while stalled");

  // the last request of a batch closes the request channel for scheduling
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_last |=> !req_ready)
    else $error("request accepted while scheduling");

  // nothing follows the final move directly
  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    mv_valid && mv_ready && mv_last |=> !mv_valid)
    else $error("move right after final move");

  // only the final move carries a travel total
  a_total_only_last: assert property (@(posedge clk) disable iff (rst)
    mv_valid && !mv_last |-> mv_total == '0)
    else $error("total on a non-final move");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !mv_valid)
    else $error("move offered after reset");

endmodule

bind scan_disk_scheduler sds_checker u_sds_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .req_last (req.last_request),
  .mv_valid (mv.valid),
  .mv_ready (mv.ready),
  .mv_last  (mv.last_move),
  .mv_total (mv.total_movement)
);

>>> verif/scan_disk_scheduler_tb.sv
// self-checking bench for scan_disk_scheduler: drives request batches, checks elevator moves
// depends on sds_pkg, sds_req_if, sds_move_if and the scheduler rtl
module scan_disk_scheduler_tb;
  import sds_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 155;

  typedef struct packed {
    logic [TRACK_BITS-1:0] from_track;
    logic [TRACK_BITS-1:0] to_track;
    logic [TOT_W-1:0]      total_movement;
    logic                  last_move;
  } move_t;

  // keeps the sorted batch and the scan order it will produce
  class scan_schedule_board;
    logic [TC_W-1:0]       track_count;
    logic                  sweep_right;
    logic [TRACK_BITS-1:0] start_track;
    logic [TRACK_BITS-1:0] held_tracks[$];
    move_t                 expected_moves[$];
    int                    failures;

    function new();
      track_count = TRACK_COUNT_RST;
      sweep_right = 1'b0;
      start_track = '0;
      failures    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TRACK_COUNT: track_count = data;
        CFG_SWEEP_RIGHT: sweep_right = data[0];
        CFG_START_TRACK: start_track = data[TRACK_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [TRACK_BITS-1:0] last_track();
      logic [TC_W-1:0] tc;
      tc = track_count;
      if (tc < TC_W'(2)) tc = TC_W'(2);
      if (tc > TRACK_LIMIT) tc = TRACK_LIMIT;
      return TRACK_BITS'(tc - TC_W'(1));
    endfunction

    function void note_request(logic [TRACK_BITS-1:0] track, logic is_last);
      logic [TRACK_BITS-1:0] edge_trk;
      logic [TRACK_BITS-1:0] head;
      logic [TRACK_BITS-1:0] path[$];
      logic [TOT_W-1:0]      total;
      move_t                 pend;
      bit                    have_pend;
      int                    pos;
      int                    i;
      edge_trk = last_track();
      if (track > edge_trk) track = edge_trk;
      // requests past the cell count are dropped, the last mark still counts
      if (held_tracks.size() < N_CELLS) begin
        pos = held_tracks.size();
        while (pos > 0 && held_tracks[pos-1] > track) pos--;
        held_tracks.insert(pos, track);
      end
      if (!is_last) return;
      head = (start_track > edge_trk) ? edge_trk : start_track;
      path.push_back(head);
      if (!sweep_right) begin
        for (i = held_tracks.size() - 1; i >= 0; i--)
          if (held_tracks[i] < head) path.push_back(held_tracks[i]);
        path.push_back('0);
        for (i = 0; i < held_tracks.size(); i++)
          if (held_tracks[i] > head) path.push_back(held_tracks[i]);
        path.push_back(edge_trk);
        total = TOT_W'(head) + TOT_W'(edge_trk);
      end else begin
        for (i = 0; i < held_tracks.size(); i++)
          if (held_tracks[i] > head) path.push_back(held_tracks[i]);
        path.push_back(edge_trk);
        for (i = held_tracks.size() - 1; i >= 0; i--)
          if (held_tracks[i] < head) path.push_back(held_tracks[i]);
        path.push_back('0);
        total = {edge_trk, 1'b0} - TOT_W'(head);
      end
      // zero-length moves vanish; the final move carries the total
      have_pend = 1'b0;
      for (i = 1; i < path.size(); i++) begin
        if (path[i] == path[i-1]) continue;
        if (have_pend) expected_moves.push_back(pend);
        pend = '{from_track: path[i-1], to_track: path[i], total_movement: '0, last_move: 1'b0};
        have_pend = 1'b1;
      end
      if (have_pend) begin
        pend.total_movement = total;
        pend.last_move      = 1'b1;
        expected_moves.push_back(pend);
      end
      held_tracks.delete();
    endfunction

    function void check_move(logic [TRACK_BITS-1:0] from_trk, logic [TRACK_BITS-1:0] to_trk,
                             logic [TOT_W-1:0] total, logic is_last);
      move_t want;
      if (expected_moves.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected move %0d->%0d total %0d last %0b",
                   from_trk, to_trk, total, is_last);
        return;
      end
      want = expected_moves.pop_front();
      if (want.from_track !== from_trk || want.to_track !== to_trk ||
          want.total_movement !== total || want.last_move !== is_last) begin
        failures++;
        if (failures <= 10)
          $display("move mismatch: expected %0d->%0d total %0d last %0b, got %0d->%0d total %0d last %0b",
                   want.from_track, want.to_track, want.total_movement, want.last_move,
                   from_trk, to_trk, total, is_last);
      end
    endfunction

    function void finish_check();
      if (expected_moves.size() != 0) begin
        $display("%0d expected moves never arrived", expected_moves.size());
        failures += expected_moves.size();
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sds_req_if  req();
  sds_move_if mv();

  scan_disk_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .mv        (mv)
  );

  scan_schedule_board    board;
  logic [TRACK_BITS-1:0] batch_tracks[$];
  int                    burst_left;
  int                    sent_items;
  int                    cur_edge;
  int                    cur_start;
  int                    cycle_count = 0;
  logic [15:0]           ready_pattern;
  int                    ready_age;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one process notes requests before checking moves, so no ordering race
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) board.write_reg(cfg_idx, cfg_wdata);
      if (req.valid && req.ready) board.note_request(req.request_track, req.last_request);
      if (mv.valid && mv.ready)
        board.check_move(mv.from_track, mv.to_track, mv.total_movement, mv.last_move);
    end
  end

  // receiver stalls follow a rotating pattern that is reloaded now and then
  always @(posedge clk) begin
    if (rst) begin
      mv.ready      <= 1'b0;
      ready_pattern <= '1;
      ready_age     <= 0;
    end else begin
      mv.ready <= ready_pattern[0];
      if (ready_age == 40) begin
        ready_age <= 0;
        case ($urandom_range(0, 3))
          0: ready_pattern <= '1;
          1: ready_pattern <= 16'($urandom) | 16'h0001;
          2: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
          default: ready_pattern <= 16'h00FF;
        endcase
      end else begin
        ready_age     <= ready_age + 1;
        ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
    end
  end

  function automatic int clamp_edge(int tc);
    if (tc < 2) return 1;
    if (tc > 65536) return 65535;
    return tc - 1;
  endfunction

  task automatic send_request(input logic [TRACK_BITS-1:0] track, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req.valid         <= 1'b1;
    req.request_track <= track;
    req.last_request  <= is_last;
    do @(posedge clk); while (!req.ready);
    burst_left--;
    sent_items++;
  endtask

  task automatic send_batch();
    foreach (batch_tracks[i]) send_request(batch_tracks[i], i == batch_tracks.size() - 1);
    batch_tracks.delete();
  endtask

  // wait until every move has come out and the sequencer has gone quiet
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int tc, input logic sweep, input int start);
    logic [CFG_IDX_W-1:0]  regs[3];
    logic [CFG_DATA_W-1:0] values[3];
    regs   = '{CFG_TRACK_COUNT, CFG_SWEEP_RIGHT, CFG_START_TRACK};
    values = '{CFG_DATA_W'(tc), CFG_DATA_W'(sweep), CFG_DATA_W'(start)};
    settle();
    for (int k = 0; k < 3; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[k];
      cfg_wdata <= values[k];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cur_edge  = clamp_edge(tc);
    cur_start = start;
  endtask

  task automatic random_config();
    int tc;
    int lim;
    int start;
    case ($urandom_range(0, 9))
      0: tc = $urandom_range(0, 3);
      1: tc = $urandom_range(0, 1) ? 65536 : 131071;
      2, 3, 4: tc = $urandom_range(2, 64);
      default: tc = $urandom_range(2, 65536);
    endcase
    lim = clamp_edge(tc);
    case ($urandom_range(0, 5))
      0: start = 0;
      1: start = lim;
      2: start = $urandom_range(0, 65535);
      default: start = $urandom_range(0, lim);
    endcase
    configure(tc, 1'($urandom_range(0, 1)), start);
  endtask

  function automatic logic [TRACK_BITS-1:0] pick_track();
    case ($urandom_range(0, 19))
      0, 1, 2: return TRACK_BITS'($urandom_range(0, 65535));
      3, 4: return TRACK_BITS'(cur_start);
      5: return '0;
      6: return TRACK_BITS'(cur_edge);
      default: return TRACK_BITS'($urandom_range(0, cur_edge));
    endcase
  endfunction

  initial begin
    int random_from;
    int batch_len;
    board = new();
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_wdata         <= '0;
    req.valid         <= 1'b0;
    req.request_track <= '0;
    req.last_request  <= 1'b0;
    burst_left = 0;
    sent_items = 0;
    cur_edge   = 199;
    cur_start  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, duplicates after clamping and a request at the head
    batch_tracks = '{16'd50, 16'd0, 16'd199, 16'd250, 16'd65535};
    send_batch();
    // smallest disk, start clamped, sweeping right
    configure(2, 1'b1, 65535);
    batch_tracks = '{16'd0, 16'd1, 16'd65535};
    send_batch();
    // full-size disk, request at the start track
    configure(65536, 1'b0, 32768);
    batch_tracks = '{16'd0, 16'd65535, 16'd32768, 16'd100, 16'd40000};
    send_batch();
    // track count below two
    configure(0, 1'b1, 0);
    batch_tracks = '{16'd1, 16'd0};
    send_batch();
    // track count above the limit
    configure(131071, 1'b1, 65535);
    batch_tracks = '{16'd65535, 16'd0, 16'd12345};
    send_batch();
    // start beyond the last track
    configure(100, 1'b0, 5000);
    batch_tracks = '{16'd99, 16'd7, 16'd200};
    send_batch();
    configure(1, 1'b0, 1);
    batch_tracks = '{16'd1, 16'd0, 16'd1};
    send_batch();

    random_from = sent_items;
    while (sent_items - random_from < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) random_config();
      // now and then send a long batch that can overfill the cell row so the tail gets dropped
      batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
      repeat (batch_len) batch_tracks.push_back(pick_track());
      send_batch();
    end

    settle();
    board.finish_check();
    if (board.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
